// ===== sv/plbr_pkg.sv =====
// Shared types, constants and codes of the price-level book reporter.
`default_nettype none
package plbr_pkg;
	localparam int BookDepthDef = 16;
	localparam int PriceBitsDef = 32;
	localparam int QtyBitsDef = 32;
	localparam int CmdBits = 3;
	localparam int PosBits = 4;
	localparam int FieldBits = 32;
	localparam int CrossBits = 16;
	localparam int InDataBits = 72;
	localparam int OutDataBits = 117;

	typedef enum logic [CmdBits-1:0] {
		CMD_ADD = 3'd0,
		CMD_CANCEL = 3'd1,
		CMD_MODIFY = 3'd2,
		CMD_TRADE = 3'd3,
		CMD_REPORT = 3'd4
	} cmd_code_t;

	typedef enum logic [2:0] {
		KIND_NONE = 3'd0,
		KIND_NAN = 3'd1,
		KIND_TRADE = 3'd2,
		KIND_CROSS = 3'd3,
		KIND_MID = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_OUT
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
		logic out_load;
	} ctrl_t;
endpackage
`default_nettype wire

// ===== sv/plbr_datapath.sv =====
// Datapath: level cell rows, trade and cross state, result register.
`default_nettype none
module plbr_datapath #(
	parameter int BOOK_DEPTH = plbr_pkg::BookDepthDef,
	parameter int PRICE_BITS = plbr_pkg::PriceBitsDef,
	parameter int QTY_BITS = plbr_pkg::QtyBitsDef
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire plbr_pkg::ctrl_t ctrl,
	input wire logic [plbr_pkg::InDataBits-1:0] in_data,
	output logic [plbr_pkg::OutDataBits-1:0] out_data
);
	import plbr_pkg::*;
	localparam int CntBits = $clog2(BOOK_DEPTH + 1);
	localparam int IdxBits = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
	localparam int CmpBits = (CntBits > PosBits) ? CntBits : PosBits;

	logic [InDataBits-1:0] item_q;
	logic [PRICE_BITS-1:0] bid_p_q [BOOK_DEPTH];
	logic [QTY_BITS-1:0] bid_n_q [BOOK_DEPTH];
	logic [PRICE_BITS-1:0] ask_p_q [BOOK_DEPTH];
	logic [QTY_BITS-1:0] ask_n_q [BOOK_DEPTH];
	logic [CntBits-1:0] bid_cnt_q, ask_cnt_q;
	logic [PRICE_BITS-1:0] tr_p_q;
	logic [QTY_BITS-1:0] tr_n_q;
	logic pend_q, seen_q;
	logic [CrossBits-1:0] cross_q;

	logic [CmdBits-1:0] cmd;
	logic sell;
	logic [CmpBits-1:0] pos, cnt;
	logic [PRICE_BITS-1:0] ip;
	logic [QTY_BITS-1:0] iq;
	logic add_ok, rm_ok, mod_ok, bad, go, crossed;
	logic [QTY_BITS:0] qsum;
	logic [PRICE_BITS:0] psum;
	logic [2:0] kind;
	logic [FieldBits-1:0] p1, p2, tq;

	assign cmd = item_q[CmdBits-1:0];
	assign sell = item_q[3];
	assign pos = CmpBits'(item_q[7:4]);
	assign ip = item_q[8 +: PRICE_BITS];
	assign iq = item_q[40 +: QTY_BITS];
	assign cnt = sell ? CmpBits'(ask_cnt_q) : CmpBits'(bid_cnt_q);
	assign add_ok = (cnt < CmpBits'(BOOK_DEPTH)) && (pos <= cnt);
	assign rm_ok = pos < cnt;
	assign mod_ok = pos < cnt;
	assign qsum = {1'b0, tr_n_q} + {1'b0, iq};
	assign crossed = bid_p_q[0] >= ask_p_q[0];
	assign psum = {1'b0, bid_p_q[0]} + {1'b0, ask_p_q[0]};

	// Latch the accepted word
	always_ff @(posedge clk) begin
		if (ctrl.load) item_q <= in_data;
	end

	// Decode the result
	always_comb begin
		kind = KIND_NONE;
		p1 = '0;
		p2 = '0;
		tq = '0;
		go = 1'b1;
		bad = 1'b0;
		unique case (cmd)
			CMD_ADD: bad = !add_ok;
			CMD_CANCEL: bad = !rm_ok;
			CMD_MODIFY: bad = !mod_ok;
			CMD_TRADE: ;
			CMD_REPORT: begin
				if (bid_cnt_q == '0 || ask_cnt_q == '0) kind = KIND_NAN;
				else if (pend_q) begin
					kind = KIND_TRADE;
					p1 = FieldBits'(tr_p_q);
					tq = FieldBits'(tr_n_q);
				end else if (crossed) begin
					if (seen_q) begin
						kind = KIND_CROSS;
						p1 = FieldBits'(bid_p_q[0]);
						p2 = FieldBits'(ask_p_q[0]);
					end
				end else begin
					kind = KIND_MID;
					p1 = FieldBits'(psum[PRICE_BITS:1]);
				end
			end
			default: go = 1'b0;
		endcase
	end

	// Shift, insert or overwrite level cells
	always_ff @(posedge clk) begin
		if (ctrl.exec) begin
			for (int i = 0; i < BOOK_DEPTH; i++) begin
				if (!sell) begin
					if (cmd == CMD_ADD && add_ok) begin
						if (CmpBits'(i) == pos) begin
							bid_p_q[i] <= ip; bid_n_q[i] <= iq;
						end else if (CmpBits'(i) > pos && i > 0) begin
							bid_p_q[i] <= bid_p_q[IdxBits'(i-1)];
							bid_n_q[i] <= bid_n_q[IdxBits'(i-1)];
						end
					end else if (cmd == CMD_CANCEL && rm_ok) begin
						if (CmpBits'(i) >= pos && i + 1 < BOOK_DEPTH) begin
							bid_p_q[i] <= bid_p_q[IdxBits'(i+1)];
							bid_n_q[i] <= bid_n_q[IdxBits'(i+1)];
						end
					end else if (cmd == CMD_MODIFY && mod_ok && CmpBits'(i) == pos) begin
						bid_p_q[i] <= ip; bid_n_q[i] <= iq;
					end
				end else begin
					if (cmd == CMD_ADD && add_ok) begin
						if (CmpBits'(i) == pos) begin
							ask_p_q[i] <= ip; ask_n_q[i] <= iq;
						end else if (CmpBits'(i) > pos && i > 0) begin
							ask_p_q[i] <= ask_p_q[IdxBits'(i-1)];
							ask_n_q[i] <= ask_n_q[IdxBits'(i-1)];
						end
					end else if (cmd == CMD_CANCEL && rm_ok) begin
						if (CmpBits'(i) >= pos && i + 1 < BOOK_DEPTH) begin
							ask_p_q[i] <= ask_p_q[IdxBits'(i+1)];
							ask_n_q[i] <= ask_n_q[IdxBits'(i+1)];
						end
					end else if (cmd == CMD_MODIFY && mod_ok && CmpBits'(i) == pos) begin
						ask_p_q[i] <= ip; ask_n_q[i] <= iq;
					end
				end
			end
		end
	end

	// Advance counts, trade and cross state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bid_cnt_q <= '0;
			ask_cnt_q <= '0;
			tr_p_q <= '0;
			tr_n_q <= '0;
			pend_q <= 1'b0;
			seen_q <= 1'b0;
			cross_q <= '0;
		end else if (ctrl.exec) begin
			if (cmd == CMD_ADD && add_ok) begin
				if (sell) ask_cnt_q <= ask_cnt_q + 1'b1;
				else bid_cnt_q <= bid_cnt_q + 1'b1;
			end
			if (cmd == CMD_CANCEL && rm_ok) begin
				if (sell) ask_cnt_q <= ask_cnt_q - 1'b1;
				else bid_cnt_q <= bid_cnt_q - 1'b1;
			end
			if (cmd == CMD_TRADE) begin
				pend_q <= 1'b1;
				if (ip == tr_p_q)
					tr_n_q <= qsum[QTY_BITS] ? '1 : qsum[QTY_BITS-1:0];
				else begin
					tr_p_q <= ip;
					tr_n_q <= iq;
				end
			end
			if (cmd == CMD_REPORT && kind == KIND_TRADE) begin
				pend_q <= 1'b0;
				seen_q <= 1'b0;
			end
			if (cmd == CMD_REPORT && bid_cnt_q != '0 && ask_cnt_q != '0 && !pend_q
					&& crossed && !seen_q)
				seen_q <= 1'b1;
			if (kind == KIND_CROSS && cross_q != '1) cross_q <= cross_q + 1'b1;
		end
	end

	// Hold the result word; cross count is taken after the update
	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			out_data <= {(kind == KIND_CROSS && cross_q != '1) ? cross_q + 1'b1 : cross_q,
				bad, go, tq, p2, p1, kind};
		end
	end

	// Counts never pass the depth; the cross count moves only on execute
	a_bid_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		bid_cnt_q <= CntBits'(BOOK_DEPTH)) else $error("bid count overflow");
	a_ask_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		ask_cnt_q <= CntBits'(BOOK_DEPTH)) else $error("ask count overflow");
	a_cross: assert property (@(posedge clk) disable iff (!arst_n)
		!ctrl.exec |=> cross_q == $past(cross_q)) else $error("cross count moved");
endmodule
`default_nettype wire

// ===== sv/plbr_ctrl.sv =====
// Controller: sequences accept, execute and deliver for one word at a time.
`default_nettype none
module plbr_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	output logic m_tvalid,
	input wire logic m_tready,
	output plbr_pkg::ctrl_t ctrl
);
	import plbr_pkg::*;
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		ctrl = '0;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					ctrl.load = 1'b1;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				ctrl.exec = 1'b1;
				ctrl.out_load = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				m_tvalid = 1'b1;
				if (m_tready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid)) else $error("both sides open");
	a_exec: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.exec |=> m_tvalid) else $error("no result after execute");
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load |=> ctrl.exec) else $error("no execute after load");
endmodule
`default_nettype wire

// ===== sv/price_level_book_reporter_top.sv =====
// Top level of the price-level book reporter.
// One word is taken, executed and delivered at a time: after acceptance the
// controller steps through execute, then deliver, where the result is offered,
// and a new word is accepted only once the result is taken, so an output stall
// holds the input. Adds and cancels shift a row of level cells in the execute
// step; levels past the count may be shifted but never reach a result.
`default_nettype none
module price_level_book_reporter_top #(
	parameter int BOOK_DEPTH = plbr_pkg::BookDepthDef,
	parameter int PRICE_BITS = plbr_pkg::PriceBitsDef,
	parameter int QTY_BITS = plbr_pkg::QtyBitsDef
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	// cmd[2:0], side[3], position[7:4], price[39:8], quantity[71:40]
	input wire logic [plbr_pkg::InDataBits-1:0] s_tdata,
	output logic m_tvalid,
	input wire logic m_tready,
	// report_kind[2:0], first_price[34:3], second_price[66:35],
	// trade_quantity[98:67], keep_going[99], bad_position[100],
	// cross_events[116:101] in 15 bytes
	output logic [119:0] m_tdata
);
	import plbr_pkg::*;
	ctrl_t ctrl;
	logic [OutDataBits-1:0] od;

	plbr_ctrl u_ctrl (.clk, .arst_n, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .ctrl);

	plbr_datapath #(.BOOK_DEPTH(BOOK_DEPTH), .PRICE_BITS(PRICE_BITS), .QTY_BITS(QTY_BITS))
	u_dp (.clk, .arst_n, .ctrl, .in_data(s_tdata), .out_data(od));

	assign m_tdata = {3'd0, od};
endmodule
`default_nettype wire

// ===== tb/price_level_book_reporter_top_tb.sv =====
// Self-checking testbench of the price-level book reporter: directed table, a bid fill, then random.
`timescale 1ns / 1ps
`default_nettype none
module price_level_book_reporter_top_tb;
	import plbr_pkg::*;

	localparam int Depth = 16;
	localparam int RandWords = 700;
	localparam longint CycleLimit = 400000;
	localparam logic [2:0] CmdEnd = 3'd5;
	localparam logic [2:0] CmdUnknown = 3'd7;

	typedef struct packed {
		logic [15:0] crosses;
		logic bad;
		logic go;
		logic [31:0] qty;
		logic [31:0] p2;
		logic [31:0] p1;
		logic [2:0] kind;
	} book_result_t;

	typedef struct {
		logic [2:0] cmd;
		logic side;
		logic [3:0] pos;
		logic [31:0] price;
		logic [31:0] qty;
		logic typed;
		book_result_t res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [InDataBits-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [119:0] m_tdata;

	price_level_book_reporter_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// predictor state
	logic [31:0] bid_px[Depth], bid_qt[Depth], ask_px[Depth], ask_qt[Depth];
	int bid_n, ask_n;
	logic [31:0] held_px, held_qt;
	logic pending, crossed;
	logic [15:0] cross_cnt;

	book_result_t expected_q[$];
	book_result_t typed_q[$];
	bit typed_flag_q[$];
	int errors = 0;
	int send_idle = 28, recv_idle = 59;
	bit hold_off = 0;
	longint cycles = 0;
	stim_row_t dir_rows[$];

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] exp);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $realtime);
		errors++;
	endtask

	// update the book model and work out the result of one word
	function automatic book_result_t book_step(input logic [2:0] cmd, input logic side,
			input logic [3:0] pos, input logic [31:0] px, input logic [31:0] qt);
		book_result_t r;
		int n;
		logic [32:0] sum;
		r = '0;
		r.go = 1'b1;
		n = side ? ask_n : bid_n;
		case (cmd)
			CMD_ADD: begin
				if (n >= Depth || pos > n) r.bad = 1'b1;
				else begin
					for (int i = Depth - 1; i > 0; i--)
						if (i > pos && i <= n) begin
							if (side) begin ask_px[i] = ask_px[i-1]; ask_qt[i] = ask_qt[i-1]; end
							else begin bid_px[i] = bid_px[i-1]; bid_qt[i] = bid_qt[i-1]; end
						end
					if (side) begin ask_px[pos] = px; ask_qt[pos] = qt; ask_n++; end
					else begin bid_px[pos] = px; bid_qt[pos] = qt; bid_n++; end
				end
			end
			CMD_CANCEL: begin
				if (pos >= n) r.bad = 1'b1;
				else begin
					for (int i = 0; i < Depth - 1; i++)
						if (i >= pos && i + 1 < n) begin
							if (side) begin ask_px[i] = ask_px[i+1]; ask_qt[i] = ask_qt[i+1]; end
							else begin bid_px[i] = bid_px[i+1]; bid_qt[i] = bid_qt[i+1]; end
						end
					if (side) ask_n--; else bid_n--;
				end
			end
			CMD_MODIFY: begin
				if (pos >= n) r.bad = 1'b1;
				else if (side) begin ask_px[pos] = px; ask_qt[pos] = qt; end
				else begin bid_px[pos] = px; bid_qt[pos] = qt; end
			end
			CMD_TRADE: begin
				pending = 1'b1;
				if (px == held_px) begin
					sum = {1'b0, held_qt} + {1'b0, qt};
					held_qt = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
				end else begin
					held_px = px;
					held_qt = qt;
				end
			end
			CMD_REPORT: begin
				if (bid_n == 0 || ask_n == 0) r.kind = KIND_NAN;
				else if (pending) begin
					r.kind = KIND_TRADE;
					r.p1 = held_px;
					r.qty = held_qt;
					pending = 1'b0;
					crossed = 1'b0;
				end else if (bid_px[0] >= ask_px[0]) begin
					if (!crossed) crossed = 1'b1;
					else begin
						r.kind = KIND_CROSS;
						r.p1 = bid_px[0];
						r.p2 = ask_px[0];
						if (cross_cnt != 16'hFFFF) cross_cnt++;
					end
				end else begin
					sum = {1'b0, bid_px[0]} + {1'b0, ask_px[0]};
					r.kind = KIND_MID;
					r.p1 = sum[32:1];
				end
			end
			default: r.go = 1'b0;
		endcase
		r.crosses = cross_cnt;
		return r;
	endfunction

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("FAIL price_level_book_reporter_top");
			$finish;
		end
	end

	// receiver: random stall, plus one long hold-off
	always @(posedge clk) begin
		if (arst_n) m_tready <= !hold_off && ($urandom_range(99) >= recv_idle);
	end

	// check each result word against the oldest expectation
	always @(posedge clk) begin
		book_result_t got, exp;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[116:0];
			if (expected_q.size() == 0) begin
				$display("unexpected result word at %0t", $realtime);
				errors++;
			end else begin
				exp = expected_q.pop_front();
				if (typed_flag_q.pop_front()) begin
					if (typed_q.pop_front() != exp)
						report_mismatch("typed vs predicted", 0, 0);
				end
				if (got.kind != exp.kind) report_mismatch("report_kind", got.kind, exp.kind);
				if (got.p1 != exp.p1) report_mismatch("first_price", got.p1, exp.p1);
				if (got.p2 != exp.p2) report_mismatch("second_price", got.p2, exp.p2);
				if (got.qty != exp.qty) report_mismatch("trade_quantity", got.qty, exp.qty);
				if (got.go != exp.go) report_mismatch("keep_going", got.go, exp.go);
				if (got.bad != exp.bad) report_mismatch("bad_position", got.bad, exp.bad);
				if (got.crosses != exp.crosses)
					report_mismatch("cross_events", got.crosses, exp.crosses);
			end
		end
	end

	// offer one word, hold it until accepted, predict on acceptance
	task automatic send_word(input logic [2:0] cmd, input logic side, input logic [3:0] pos,
			input logic [31:0] px, input logic [31:0] qt, input bit typed,
			input book_result_t res);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {qt, px, pos, side, cmd};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		expected_q.push_back(book_step(cmd, side, pos, px, qt));
		typed_flag_q.push_back(typed);
		if (typed) typed_q.push_back(res);
	endtask

	function automatic book_result_t typed_res(input logic [2:0] kind, input logic go,
			input logic bad, input logic [15:0] crosses);
		book_result_t r;
		r = '0;
		r.kind = kind;
		r.go = go;
		r.bad = bad;
		r.crosses = crosses;
		return r;
	endfunction

	function automatic stim_row_t row(input logic [2:0] cmd, input logic side,
			input logic [3:0] pos, input logic [31:0] px, input logic [31:0] qt,
			input logic typed, input book_result_t res);
		stim_row_t s;
		s.cmd = cmd; s.side = side; s.pos = pos; s.price = px; s.qty = qt;
		s.typed = typed; s.res = res;
		return s;
	endfunction

	// random word: mostly in-range book traffic with reports
	task automatic send_random;
		logic [2:0] cmd;
		logic side;
		int n, r;
		logic [3:0] pos;
		logic [31:0] px;
		side = $urandom_range(1);
		n = side ? ask_n : bid_n;
		r = $urandom_range(99);
		if (r < 30) cmd = CMD_ADD;
		else if (r < 45) cmd = CMD_CANCEL;
		else if (r < 55) cmd = CMD_MODIFY;
		else if (r < 65) cmd = CMD_TRADE;
		else if (r < 95) cmd = CMD_REPORT;
		else cmd = 3'($urandom_range(7, 5));
		if ($urandom_range(9) == 0) pos = 4'($urandom);
		else pos = 4'($urandom_range(n > 15 ? 15 : n));
		case ($urandom_range(3))
			0: px = $urandom;
			1: px = 32'hFFFF_FFF0 + $urandom_range(15);
			default: px = 1000 + $urandom_range(20);
		endcase
		if (cmd == CMD_TRADE && $urandom_range(1)) px = held_px;
		send_word(cmd, side, pos, px, $urandom_range(1) ? $urandom : 32'hFFFF_FFFF - $urandom_range(3),
			0, '0);
	endtask

	initial begin
		book_result_t none;
		none = '0;
		bid_n = 0; ask_n = 0; held_px = 0; held_qt = 0;
		pending = 0; crossed = 0; cross_cnt = 0;
		// directed rows: empty book, bad positions, extremes, cross, trade
		dir_rows.push_back(row(CMD_REPORT, 0, 0, 0, 0, 1, typed_res(KIND_NAN, 1, 0, 0)));
		dir_rows.push_back(row(CMD_CANCEL, 0, 0, 0, 0, 1, typed_res(KIND_NONE, 1, 1, 0)));
		dir_rows.push_back(row(CMD_MODIFY, 1, 0, 5, 5, 1, typed_res(KIND_NONE, 1, 1, 0)));
		dir_rows.push_back(row(CMD_ADD, 0, 1, 5, 5, 1, typed_res(KIND_NONE, 1, 1, 0)));
		dir_rows.push_back(row(CMD_ADD, 0, 0, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 0, none));
		dir_rows.push_back(row(CMD_REPORT, 0, 0, 0, 0, 1, typed_res(KIND_NAN, 1, 0, 0)));
		dir_rows.push_back(row(CMD_ADD, 1, 0, 32'hFFFF_FFFF, 0, 0, none));
		dir_rows.push_back(row(CMD_REPORT, 1, 15, 0, 0, 0, none));
		dir_rows.push_back(row(CMD_MODIFY, 1, 0, 32'h0, 32'h1, 0, none));
		dir_rows.push_back(row(CMD_REPORT, 0, 0, 0, 0, 0, none));
		dir_rows.push_back(row(CMD_REPORT, 0, 0, 0, 0, 0, none));
		dir_rows.push_back(row(CMD_REPORT, 0, 0, 0, 0, 0, none));
		dir_rows.push_back(row(CMD_TRADE, 0, 0, 7, 32'hFFFF_FFF0, 0, none));
		dir_rows.push_back(row(CMD_TRADE, 1, 0, 7, 32'h100, 0, none));
		dir_rows.push_back(row(CMD_TRADE, 1, 0, 8, 3, 0, none));
		dir_rows.push_back(row(CMD_TRADE, 1, 0, 8, 32'hFFFF_FFFF, 0, none));
		dir_rows.push_back(row(CMD_REPORT, 0, 0, 0, 0, 0, none));
		dir_rows.push_back(row(CMD_REPORT, 0, 0, 0, 0, 0, none));
		dir_rows.push_back(row(CMD_CANCEL, 1, 0, 0, 0, 0, none));
		dir_rows.push_back(row(CMD_CANCEL, 1, 1, 0, 0, 1, typed_res(KIND_NONE, 1, 1, 2)));
		dir_rows.push_back(row(CmdEnd, 1, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
			typed_res(KIND_NONE, 0, 0, 2)));
		dir_rows.push_back(row(CmdUnknown, 0, 0, 0, 0, 1, typed_res(KIND_NONE, 0, 0, 2)));
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		@(posedge clk);
		foreach (dir_rows[i])
			send_word(dir_rows[i].cmd, dir_rows[i].side, dir_rows[i].pos, dir_rows[i].price,
				dir_rows[i].qty, dir_rows[i].typed, dir_rows[i].res);
		// fill the bid side past full to hit the bad-position result on a full side
		for (int i = 0; i < Depth + 2; i++)
			send_word(CMD_ADD, 0, 4'($urandom_range(bid_n > 15 ? 15 : bid_n)), $urandom, $urandom,
				0, '0);
		for (int i = 0; i < RandWords; i++) begin
			if (i == RandWords / 3) begin send_idle = 59; recv_idle = 28; end
			if (i == 2 * RandWords / 3) begin send_idle = 0; recv_idle = 0; end
			if (i == RandWords / 2) begin
				hold_off = 1;
				fork
					begin
						repeat (200) @(posedge clk);
						hold_off = 0;
					end
				join_none
			end
			send_random();
		end
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("PASS price_level_book_reporter_top");
		else
			$display("FAIL price_level_book_reporter_top");
		$finish;
	end
endmodule
`default_nettype wire

// ===== filelist.f =====
sv/plbr_pkg.sv
sv/plbr_datapath.sv
sv/plbr_ctrl.sv
sv/price_level_book_reporter_top.sv
tb/price_level_book_reporter_top_tb.sv
